@@ hdl/astar_open_list_table_unit_assert.svh @@
// assertion macros for the open list table unit
// clocked on clk, disabled while rst_n is low
`ifndef ASTAR_OPEN_LIST_TABLE_UNIT_ASSERT_SVH
`define ASTAR_OPEN_LIST_TABLE_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define AOLT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define AOLT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/aolt_pkg.sv @@
// types and constants for the open list table unit
// used by aolt_cell and astar_open_list_table_unit
`default_nettype none

package aolt_pkg;

    localparam int CMD_W    = 3;
    localparam int COORD_W  = 8;
    localparam int COST_W   = 16;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 7;
    // wide enough for a position in the deepest supported table
    localparam int IDX_W    = 10;

    localparam logic [CMD_W-1:0] CMD_INSERT      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MIN_F       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ_POS    = 3'd5;
    localparam logic [CMD_W-1:0] CMD_READ_OLDEST = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [COORD_W-1:0] node_x;
        logic [COORD_W-1:0] node_y;
        logic [COST_W-1:0]  cost_g;
        logic [COST_W-1:0]  cost_h;
        logic [COST_W-1:0]  cost_f;
        logic [COORD_W-1:0] parent_col;
        logic [COORD_W-1:0] parent_row;
        logic [POS_W-1:0]   position;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    where_found;
        logic [COORD_W-1:0]  out_x;
        logic [COORD_W-1:0]  out_y;
        logic [COST_W-1:0]   out_g;
        logic [COST_W-1:0]   out_h;
        logic [COST_W-1:0]   out_f;
        logic [COORD_W-1:0]  out_parent_x;
        logic [COORD_W-1:0]  out_parent_y;
        logic [TOTAL_W-1:0]  entry_total;
    } out_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COST_W-1:0]  g;
        logic [COST_W-1:0]  h;
        logic [COST_W-1:0]  f;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
    } entry_t;

    // query token walking the cell chain, one cell per cycle
    typedef struct packed {
        logic               active;
        logic [CMD_W-1:0]   cmd;
        logic [COORD_W-1:0] key_x;
        logic [COORD_W-1:0] key_y;
        logic [POS_W-1:0]   pos;
        logic               found;
        logic [IDX_W-1:0]   best_pos;
        entry_t             best;
    } probe_t;

    // table shift control, shared by every cell
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [IDX_W-1:0] del_pos;
    } shift_ctl_t;

endpackage

`default_nettype wire

@@ hdl/astar_open_list_table_unit.sv @@
// Open list table for a path search: up to TABLE_DEPTH nodes, newest at
// position 0, held in a chain of cells. Insert, clear and the unused command
// code finish at once: the result strobe (done) comes in the cycle after the
// item is accepted and busy stays low, so one such item can be taken every
// cycle. Delete, search, get-min-f, read-at-position and read-oldest send a
// query token down the chain one cell per cycle; busy is high from the
// accepting edge until done comes, so no new item is taken until the token
// has passed every cell. The length of the cell chain sets how long these
// items take. A delete closes the gap in the table on the same edge that loads
// its result. Results are held on the result port for the single cycle that
// done is high; the receiver cannot stall them, so it must take every one.
`default_nettype none

`include "astar_open_list_table_unit_assert.svh"

module astar_open_list_table_unit
    import aolt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int COORD_BITS  = 8,
    parameter int COST_BITS   = 16
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire in_item_t request,
    output logic          done,
    output out_item_t     result
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [COORD_W-1:0] COORD_MASK =
        COORD_W'((64'(1) << COORD_BITS) - 64'(1));
    localparam logic [COST_W-1:0] COST_MASK =
        COST_W'((64'(1) << COST_BITS) - 64'(1));

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    out_item_t        result_reg;
    out_item_t        result_next;

    entry_t           entry_w [TABLE_DEPTH];
    probe_t           probe_w [TABLE_DEPTH+1];
    entry_t           new_entry;
    shift_ctl_t       ctl;
    probe_t           tail;

    logic             accept;
    logic             is_probe_cmd;
    logic             full;
    logic             del_hit;

    assign accept = start && !busy_reg;
    assign full   = count_reg == CNT_W'(TABLE_DEPTH);
    assign is_probe_cmd = (request.command == CMD_DELETE) ||
                          (request.command == CMD_SEARCH) ||
                          (request.command == CMD_MIN_F) ||
                          (request.command == CMD_READ_POS) ||
                          (request.command == CMD_READ_OLDEST);

    assign new_entry.x  = request.node_x & COORD_MASK;
    assign new_entry.y  = request.node_y & COORD_MASK;
    assign new_entry.g  = request.cost_g & COST_MASK;
    assign new_entry.h  = request.cost_h & COST_MASK;
    assign new_entry.f  = request.cost_f & COST_MASK;
    assign new_entry.px = request.parent_col & COORD_MASK;
    assign new_entry.py = request.parent_row & COORD_MASK;

    // token into the head cell
    always_comb
    begin
        probe_w[0]          = '0;
        probe_w[0].active   = accept && is_probe_cmd;
        probe_w[0].cmd      = request.command;
        probe_w[0].key_x    = new_entry.x;
        probe_w[0].key_y    = new_entry.y;
        probe_w[0].pos      = request.position;
    end

    assign tail    = probe_w[TABLE_DEPTH];
    assign del_hit = tail.active && tail.found && (tail.cmd == CMD_DELETE);

    assign ctl.ins     = accept && (request.command == CMD_INSERT) && !full;
    assign ctl.del     = del_hit;
    assign ctl.del_pos = tail.best_pos;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            entry_t prev_e;
            entry_t next_e;
            if (gi == 0)
            begin : g_head
                assign prev_e = new_entry;
            end
            else
            begin : g_mid
                assign prev_e = entry_w[gi-1];
            end
            if (gi == TABLE_DEPTH - 1)
            begin : g_last
                assign next_e = entry_w[gi];
            end
            else
            begin : g_body
                assign next_e = entry_w[gi+1];
            end

            aolt_cell #(
                .INDEX (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .count      (count_reg),
                .ctl        (ctl),
                .prev_entry (prev_e),
                .next_entry (next_e),
                .entry      (entry_w[gi]),
                .probe_in   (probe_w[gi]),
                .probe_out  (probe_w[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        if (tail.active)
        begin
            busy_next   = 1'b0;
            done_next   = 1'b1;
            result_next = '0;
            if (del_hit)
            begin
                count_next = count_reg - CNT_W'(1);
            end
            if (tail.found)
            begin
                result_next.status       = ST_OK;
                result_next.where_found  = POS_W'(tail.best_pos);
                result_next.out_x        = tail.best.x;
                result_next.out_y        = tail.best.y;
                result_next.out_g        = tail.best.g;
                result_next.out_h        = tail.best.h;
                result_next.out_f        = tail.best.f;
                result_next.out_parent_x = tail.best.px;
                result_next.out_parent_y = tail.best.py;
            end
            else
            begin
                case (tail.cmd)
                    CMD_MIN_F, CMD_READ_OLDEST:
                    begin
                        result_next.status = ST_EMPTY;
                    end
                    CMD_READ_POS:
                    begin
                        result_next.status = (count_reg == '0) ? ST_EMPTY : ST_NOT_FOUND;
                    end
                    default:
                    begin
                        result_next.status = ST_NOT_FOUND;
                    end
                endcase
            end
            result_next.entry_total = TOTAL_W'(count_next);
        end
        else if (accept)
        begin
            if (is_probe_cmd)
            begin
                busy_next = 1'b1;
            end
            else
            begin
                done_next   = 1'b1;
                result_next = '0;
                case (request.command)
                    CMD_INSERT:
                    begin
                        if (full)
                        begin
                            result_next.status = ST_FULL;
                        end
                        else
                        begin
                            count_next                = count_reg + CNT_W'(1);
                            result_next.status        = ST_OK;
                            result_next.out_x         = new_entry.x;
                            result_next.out_y         = new_entry.y;
                            result_next.out_g         = new_entry.g;
                            result_next.out_h         = new_entry.h;
                            result_next.out_f         = new_entry.f;
                            result_next.out_parent_x  = new_entry.px;
                            result_next.out_parent_y  = new_entry.py;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        count_next         = '0;
                        result_next.status = ST_OK;
                    end
                    default:
                    begin
                        result_next.status = ST_NOT_FOUND;
                    end
                endcase
                result_next.entry_total = TOTAL_W'(count_next);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    `AOLT_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH), "fill count beyond table depth")
    `AOLT_ASSERT_IMP(a_tail_busy, tail.active, busy_reg, "query token left the chain while idle")
    `AOLT_ASSERT_IMP(a_done_on_fall, $fell(busy_reg), done_reg, "query finished without a result")
    `AOLT_ASSERT_NEXT(a_insert_count, ctl.ins, count_reg == CNT_W'($past(count_reg) + CNT_W'(1)), "insert did not grow the table")

endmodule

`default_nettype wire

@@ hdl/aolt_cell.sv @@
// one table slot: holds an entry and one stage of the query chain
// depends on aolt_pkg
`default_nettype none

module aolt_cell
    import aolt_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CNT_W-1:0] count,
    input  wire shift_ctl_t       ctl,
    input  wire entry_t           prev_entry,
    input  wire entry_t           next_entry,
    output entry_t                entry,
    input  wire probe_t           probe_in,
    output probe_t                probe_out
);

    entry_t entry_reg;
    probe_t probe_reg;
    probe_t probe_next;
    logic   in_range;
    logic   key_eq;
    logic   hit;

    assign in_range = count > CNT_W'(INDEX);
    assign key_eq   = (entry_reg.x == probe_in.key_x) && (entry_reg.y == probe_in.key_y);

    always_comb
    begin
        hit = 1'b0;
        case (probe_in.cmd)
            CMD_DELETE, CMD_SEARCH:
            begin
                hit = in_range && !probe_in.found && key_eq;
            end
            CMD_MIN_F:
            begin
                // strict compare keeps the newest of equal costs
                hit = in_range && (!probe_in.found || (entry_reg.f < probe_in.best.f));
            end
            CMD_READ_POS:
            begin
                hit = in_range && (INDEX < (1 << POS_W)) && (probe_in.pos == POS_W'(INDEX));
            end
            CMD_READ_OLDEST:
            begin
                hit = count == CNT_W'(INDEX + 1);
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase

        probe_next = probe_in;
        if (hit)
        begin
            probe_next.found    = 1'b1;
            probe_next.best_pos = IDX_W'(INDEX);
            probe_next.best     = entry_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
        end
    end

    // slots open up at the head on insert and close over a removed slot on delete
    always_ff @(posedge clk)
    begin
        if (ctl.ins)
        begin
            entry_reg <= prev_entry;
        end
        else if (ctl.del && (IDX_W'(INDEX) >= ctl.del_pos))
        begin
            entry_reg <= next_entry;
        end
    end

    assign entry     = entry_reg;
    assign probe_out = probe_reg;

endmodule

`default_nettype wire
